@@ design/spfir_pkg.sv @@
// shared constants, codes and control types of the sample player with fir
package spfir_pkg;

    localparam int DEF_SAMPLE_DEPTH = 65536;
    localparam int DEF_MAX_TAPS     = 64;

    localparam int POS_W     = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 46;

    localparam logic signed [15:0] TAP_FULL_SCALE = 16'sh7fff;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_TAP_L  = 2'd2;
    localparam logic [1:0] ACT_TAP_R  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVOLVE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd6;

    typedef struct packed {
        logic load_tick;
        logic write_item;
        logic issue;
        logic scale;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic remain_zero;
        logic pipe_busy;
    } t_stat;

endpackage

@@ design/spfir_ctrl.sv @@
// sequencing state machine of the sample player with fir
module spfir_ctrl
    import spfir_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MAC   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_SCALE = 5'b01000,
        S_SUM   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_TICK) begin
                        o_cmd.load_tick = 1'b1;
                        n_state         = S_MAC;
                    end else begin
                        o_cmd.write_item = 1'b1;
                    end
                end
            end
            S_MAC: begin
                if (i_stat.remain_zero) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/spfir_dp.sv @@
// datapath: registers, memories, position logic, tap mac and gain scaling
module spfir_dp
    import spfir_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
    parameter int MAX_TAPS     = DEF_MAX_TAPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic [1:0]              i_action,
    input  logic                    i_trigger,
    input  logic [15:0]             i_address,
    input  logic signed [15:0]      i_data,
    output logic signed [OUT_W-1:0] o_left_out,
    output logic signed [OUT_W-1:0] o_right_out,
    output logic                    o_playing
);

    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int TW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = 33 + $clog2(MAX_TAPS);
    localparam int LO_W  = ACC_W / 2;
    localparam int HI_W  = ACC_W - LO_W;
    localparam int PL_W  = LO_W + 16;
    localparam int PH_W  = HI_W + 17;
    localparam int P_W   = ACC_W + 17;
    localparam int Q_W   = P_W - 8;
    localparam int E_W   = ((Q_W > OUT_W) ? Q_W : OUT_W) + 1;
    localparam logic signed [E_W-1:0] OUT_HI =
        {{(E_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [E_W-1:0] OUT_LO =
        {{(E_W - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    // configuration
    logic             r_loop;
    logic             r_stereo;
    logic [16:0]      r_length;
    logic [15:0]      r_loop_start;
    logic             r_conv;
    logic [6:0]       r_tap_count;
    logic [15:0]      r_gain;

    // play state
    logic [POS_W-1:0] r_pos;
    logic             r_flag;

    // storage
    logic [15:0]      r_sample_mem [SAMPLE_DEPTH];
    logic [15:0]      r_taps_l [MAX_TAPS];
    logic [15:0]      r_taps_r [MAX_TAPS];

    // mac loop
    logic signed [17:0] r_j;
    logic [TW-1:0]      r_tap;
    logic [CNT_W-1:0]   r_remain;
    logic [15:0]        r_sl, r_sr, r_tl, r_tr;
    logic               r_v1, r_lv1, r_rv1, r_v2;
    logic signed [31:0] r_prod_l, r_prod_r;
    logic signed [ACC_W-1:0] r_acc_l, r_acc_r;
    logic signed [PH_W-1:0]  r_ph_l, r_ph_r;
    logic [PL_W-1:0]         r_pl_l, r_pl_r;

    logic signed [OUT_W-1:0] r_left_out, r_right_out;
    logic                    r_playing;

    // combinational
    logic [POS_W-1:0] p0, step17, n_pos;
    logic             f0;
    logic [31:0]      n_taps, tc32;
    logic [31:0]      addr32, l_idx, r_idx;
    logic             l_ok, r_ok;
    logic signed [15:0] tl_s, tr_s;
    logic signed [31:0] n_prod_l, n_prod_r;

    function automatic logic [OUT_W-1:0] f_finish(
        input logic signed [PH_W-1:0] ph,
        input logic [PL_W-1:0]        pl
    );
        logic signed [P_W-1:0] full;
        logic signed [E_W-1:0] qx;
        logic [OUT_W-1:0]      res;
        full = $signed({ph, {LO_W{1'b0}}}) + $signed({{(P_W - PL_W){1'b0}}, pl});
        qx   = {{(E_W - Q_W){full[P_W-1]}}, full[P_W-1:8]};
        if (qx > OUT_HI) begin
            res = OUT_HI[OUT_W-1:0];
        end else if (qx < OUT_LO) begin
            res = OUT_LO[OUT_W-1:0];
        end else begin
            res = qx[OUT_W-1:0];
        end
        return res;
    endfunction

    // position update for a tick
    always_comb begin
        step17 = r_stereo ? 17'd2 : 17'd1;
        p0     = r_pos;
        f0     = r_flag;
        if (i_trigger) begin
            if (f0) begin
                p0 = '0;
            end else begin
                f0 = 1'b1;
            end
        end
        if (p0 >= r_length) begin
            if (r_loop) begin
                p0 = {1'b0, r_loop_start};
            end else begin
                f0 = 1'b0;
                p0 = '0;
            end
        end
        n_pos = p0 + step17;
        tc32  = {25'b0, r_tap_count};
        if (!f0) begin
            n_taps = 32'd0;
        end else if (!r_conv) begin
            n_taps = 32'd1;
        end else if (tc32 > 32'(MAX_TAPS)) begin
            n_taps = 32'(MAX_TAPS);
        end else begin
            n_taps = tc32;
        end
    end

    // sample indexes for the current tap
    always_comb begin
        addr32 = {16'b0, i_address};
        l_idx  = {15'b0, r_j[16:0]};
        r_idx  = l_idx + {31'b0, r_stereo};
        l_ok   = !r_j[17] && (l_idx < 32'(SAMPLE_DEPTH));
        r_ok   = !r_j[17] && (r_idx < 32'(SAMPLE_DEPTH));
    end

    always_comb begin
        tl_s     = r_conv ? $signed(r_tl) : TAP_FULL_SCALE;
        tr_s     = r_conv ? $signed(r_tr) : TAP_FULL_SCALE;
        n_prod_l = r_lv1 ? (32'(tl_s) * 32'($signed(r_sl))) : 32'sd0;
        n_prod_r = r_rv1 ? (32'(tr_s) * 32'($signed(r_sr))) : 32'sd0;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop       <= 1'b0;
            r_stereo     <= 1'b0;
            r_length     <= '0;
            r_loop_start <= '0;
            r_conv       <= 1'b0;
            r_tap_count  <= 7'd1;
            r_gain       <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOOP_ENABLE: r_loop       <= i_cfg_data[0];
                CFG_STEREO:      r_stereo     <= i_cfg_data[0];
                CFG_LENGTH:      r_length     <= i_cfg_data[16:0];
                CFG_LOOP_START:  r_loop_start <= i_cfg_data[15:0];
                CFG_CONVOLVE:    r_conv       <= i_cfg_data[0];
                CFG_TAP_COUNT:   r_tap_count  <= i_cfg_data[6:0];
                CFG_GAIN:        r_gain       <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_flag   <= 1'b0;
            r_remain <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (i_cmd.load_tick) begin
                r_pos    <= n_pos;
                r_flag   <= f0;
                r_remain <= n_taps[CNT_W-1:0];
            end else if (i_cmd.issue) begin
                r_remain <= r_remain - 1'b1;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    // tap walk and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tick) begin
            r_j     <= $signed({1'b0, p0});
            r_tap   <= '0;
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_j   <= r_j - $signed({16'b0, r_stereo, !r_stereo});
                r_tap <= r_tap + 1'b1;
            end
            if (r_v2) begin
                r_acc_l <= r_acc_l + {{(ACC_W - 32){r_prod_l[31]}}, r_prod_l};
                r_acc_r <= r_acc_r + {{(ACC_W - 32){r_prod_r[31]}}, r_prod_r};
            end
        end
        if (i_cmd.issue) begin
            r_lv1 <= l_ok;
            r_rv1 <= r_ok;
        end
        r_prod_l <= n_prod_l;
        r_prod_r <= n_prod_r;
    end

    // sample memory, one write port and two read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_item && (i_action == ACT_SAMPLE)
                && (addr32 < 32'(SAMPLE_DEPTH))) begin
            r_sample_mem[addr32[AW-1:0]] <= i_data;
        end
        if (i_cmd.issue) begin
            r_sl <= r_sample_mem[l_idx[AW-1:0]];
            r_sr <= r_sample_mem[r_idx[AW-1:0]];
        end
    end

    // tap tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_item && (addr32 < 32'(MAX_TAPS))) begin
            if (i_action == ACT_TAP_L) begin
                r_taps_l[i_address[TW-1:0]] <= i_data;
            end
            if (i_action == ACT_TAP_R) begin
                r_taps_r[i_address[TW-1:0]] <= i_data;
            end
        end
        if (i_cmd.issue) begin
            r_tl <= r_taps_l[r_tap];
            r_tr <= r_taps_r[r_tap];
        end
    end

    // gain scaling in two partial products, then floor and saturate
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_pl_l <= PL_W'(r_acc_l[LO_W-1:0]) * PL_W'(r_gain);
            r_pl_r <= PL_W'(r_acc_r[LO_W-1:0]) * PL_W'(r_gain);
            r_ph_l <= PH_W'($signed(r_acc_l[ACC_W-1:LO_W])) * PH_W'($signed({1'b0, r_gain}));
            r_ph_r <= PH_W'($signed(r_acc_r[ACC_W-1:LO_W])) * PH_W'($signed({1'b0, r_gain}));
        end
        if (i_cmd.out_load) begin
            r_left_out  <= f_finish(r_ph_l, r_pl_l);
            r_right_out <= f_finish(r_ph_r, r_pl_r);
            r_playing   <= r_flag;
        end
    end

    assign o_stat.remain_zero = (r_remain == '0);
    assign o_stat.pipe_busy   = r_v1 | r_v2;
    assign o_left_out         = r_left_out;
    assign o_right_out        = r_right_out;
    assign o_playing          = r_playing;

endmodule

@@ design/sample_player_fir.sv @@
// top level of the sample playback voice with fir convolution
// sequence: a write is taken while idle; a tick runs n taps through the single mac loop,
//   then drains, scales and loads its result; n = tap_count capped at MAX_TAPS, 1 without
//   convolution, 0 stopped; a result waiting on the output stall holds back the next one
// input stall: held from a tick until its result is loaded, so ticks run one at a time
// reset: synchronous active low; clears position, play flag, registers, handshakes only
module sample_player_fir
    import spfir_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
    parameter int MAX_TAPS     = DEF_MAX_TAPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_action,
    input  logic                    i_trigger,
    input  logic [15:0]             i_address,
    input  logic signed [15:0]      i_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_left_out,
    output logic signed [OUT_W-1:0] o_right_out,
    output logic                    o_playing
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    spfir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spfir_dp #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .MAX_TAPS     (MAX_TAPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_action    (i_action),
        .i_trigger   (i_trigger),
        .i_address   (i_address),
        .i_data      (i_data),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .o_playing   (o_playing)
    );

endmodule
